[rtl/adsr_sns_pkg.sv]
// Shared types, constants and table functions of the ADSR sine note sample block.
package adsr_sns_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_INDEX_BITS = 12;
  localparam int SAMPLE_BITS     = 16;

  localparam int A4_W    = 32;
  localparam int LEN_W   = 24;
  localparam int IDX_W   = 25;
  localparam int STG_W   = 20;
  localparam int SUS_W   = 16;
  localparam int RATIO_W = 17;
  localparam int PROD_W  = A4_W + RATIO_W;
  localparam int SH_W    = 5;
  localparam int MUL_A_W = STG_W;
  localparam int AMP_W   = 17;
  localparam int NUM_W   = 36;
  localparam int QUO_W   = 17;
  localparam int REM_W   = NUM_W + 1;
  localparam int DIV_LAT = QUO_W;

  localparam int MAG_W   = SAMPLE_BITS - 1;
  localparam int QUARTER = 1 << (SINE_INDEX_BITS - 2);
  localparam int ROM_AW  = SINE_INDEX_BITS - 1;
  localparam longint unsigned FULL_SCALE  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);

  typedef enum logic [1:0] {
    STG_ATTACK,
    STG_DECAY,
    STG_SUSTAIN,
    STG_RELEASE
  } stage_t;

  typedef enum logic [2:0] {
    REG_A4,
    REG_ATTACK,
    REG_DECAY,
    REG_RELEASE,
    REG_SUSTAIN
  } reg_idx_t;

  typedef struct packed {
    logic [A4_W-1:0]  a4_phase_step;
    logic [STG_W-1:0] attack_samples;
    logic [STG_W-1:0] decay_samples;
    logic [STG_W-1:0] release_samples;
    logic [SUS_W-1:0] sus_level;
  } cfg_t;

  typedef struct packed {
    logic                  past_end;
    stage_t                stage;
    logic [PHASE_BITS-1:0] step;
    logic [IDX_W-1:0]      idx;
    logic [NUM_W-1:0]      num;
    logic [STG_W-1:0]      den;
  } work_t;

  typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER];

  // 2^((s-9)/12) in Q16
  function automatic logic [RATIO_W-1:0] semi_ratio(input logic [3:0] s);
    logic [RATIO_W-1:0] r;
    case (s)
      4'd0:    r = RATIO_W'(38968);
      4'd1:    r = RATIO_W'(41285);
      4'd2:    r = RATIO_W'(43740);
      4'd3:    r = RATIO_W'(46341);
      4'd4:    r = RATIO_W'(49097);
      4'd5:    r = RATIO_W'(52016);
      4'd6:    r = RATIO_W'(55109);
      4'd7:    r = RATIO_W'(58386);
      4'd8:    r = RATIO_W'(61858);
      4'd9:    r = RATIO_W'(65536);
      4'd10:   r = RATIO_W'(69433);
      4'd11:   r = RATIO_W'(73562);
      default: r = RATIO_W'(38968);
    endcase
    return r;
  endfunction

  // Taylor series to the t^11 term in Q30, scaled to full scale
  function automatic logic [MAG_W-1:0] sine_mag(input int q);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] mag;
    t    = (64'(q) * HALF_PI_Q30) >> (SINE_INDEX_BITS - 2);
    t2   = (t * t) >> 30;
    term = t;
    sum  = longint'(t);
    term = ((term * t2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * t2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * t2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * t2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    mag = (64'(sum) * FULL_SCALE + (64'd1 << 29)) >> 30;
    if (mag > FULL_SCALE) begin
      mag = FULL_SCALE;
    end
    return mag[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int i = 0; i <= QUARTER; i++) begin
      r[i] = sine_mag(i);
    end
    return r;
  endfunction

endpackage

[rtl/adsr_sns_front.sv]
// Front end: accepts requests, picks the envelope stage and prepares step and divider operands.
module adsr_sns_front
  import adsr_sns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              start,
  input  logic [3:0]        semitone,
  input  logic [3:0]        octave,
  input  logic [LEN_W-1:0]  note_length,
  input  logic [IDX_W-1:0]  sample_index,
  input  logic [QCNT_W-1:0] q_level,
  output logic              busy,
  output logic              push,
  output work_t             push_data
);

  logic               acc;
  logic [IDX_W-1:0]   sum_lr;
  logic [IDX_W-1:0]   sum_ad;
  logic               is_past;
  logic               semi_hi;
  logic [3:0]         semi_eff;
  stage_t             stg;
  logic [MUL_A_W-1:0] ma;
  logic [AMP_W-1:0]   mb;
  logic [STG_W-1:0]   dn;

  logic               v1;
  logic               past1;
  stage_t             stage1;
  logic [RATIO_W-1:0] ratio1;
  logic [SH_W-1:0]    sh1;
  logic [IDX_W-1:0]   idx1;
  logic [MUL_A_W-1:0] ma1;
  logic [AMP_W-1:0]   mb1;
  logic [STG_W-1:0]   den1;

  logic               v2;
  logic               past2;
  stage_t             stage2;
  logic [PROD_W-1:0]  prod2;
  logic [SH_W-1:0]    sh2;
  logic [IDX_W-1:0]   idx2;
  logic [NUM_W-1:0]   num2;
  logic [STG_W-1:0]   den2;

  logic [PROD_W:0]    rounded;

  // hold off while the queue could not take what is in flight
  assign busy = (q_level + QCNT_W'(v1) + QCNT_W'(v2)) >= QCNT_W'(QDEPTH);
  assign acc  = start & ~busy;

  always_comb begin
    sum_lr   = IDX_W'(note_length) + IDX_W'(cfg.release_samples);
    sum_ad   = IDX_W'(cfg.attack_samples) + IDX_W'(cfg.decay_samples);
    is_past  = sample_index >= sum_lr;
    semi_hi  = semitone inside {[4'd12:4'd15]};
    semi_eff = semi_hi ? semitone - 4'd12 : semitone;
    ma       = '0;
    mb       = '0;
    dn       = STG_W'(1);
    if (is_past) begin
      stg = STG_RELEASE;
    end else if (sample_index < IDX_W'(cfg.attack_samples)) begin
      stg = STG_ATTACK;
      ma  = sample_index[MUL_A_W-1:0];
      mb  = AMP_ONE;
      dn  = cfg.attack_samples;
    end else if (sample_index < sum_ad) begin
      stg = STG_DECAY;
      ma  = MUL_A_W'(sample_index - IDX_W'(cfg.attack_samples));
      mb  = AMP_ONE - AMP_W'(cfg.sus_level);
      dn  = cfg.decay_samples;
    end else if (sample_index < IDX_W'(note_length)) begin
      stg = STG_SUSTAIN;
    end else begin
      stg = STG_RELEASE;
      ma  = MUL_A_W'(sum_lr - sample_index);
      mb  = AMP_W'(cfg.sus_level);
      dn  = cfg.release_samples;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= acc;
      v2 <= v1;
    end
    past1  <= is_past;
    stage1 <= stg;
    ratio1 <= semi_ratio(semi_eff);
    sh1    <= semi_hi ? SH_W'(19) - SH_W'(octave) : SH_W'(20) - SH_W'(octave);
    idx1   <= sample_index;
    ma1    <= ma;
    mb1    <= mb;
    den1   <= dn;

    past2  <= past1;
    stage2 <= stage1;
    prod2  <= PROD_W'(cfg.a4_phase_step) * PROD_W'(ratio1);
    sh2    <= sh1;
    idx2   <= idx1;
    num2   <= NUM_W'(ma1 * mb1);
    den2   <= den1;
  end

  // round to nearest on the octave shift
  assign rounded = {1'b0, prod2} + ((PROD_W + 1)'(1) << (sh2 - SH_W'(1)));

  always_comb begin
    push               = v2;
    push_data.past_end = past2;
    push_data.stage    = stage2;
    push_data.step     = PHASE_BITS'(rounded >> sh2);
    push_data.idx      = idx2;
    push_data.num      = num2;
    push_data.den      = den2;
  end

endmodule

[rtl/adsr_sns_queue.sv]
// Short first-in first-out queue between front and back ends.
module adsr_sns_queue
  import adsr_sns_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  work_t             din,
  input  logic              pop,
  output work_t             dout,
  output logic              empty,
  output logic [QCNT_W-1:0] level
);

  work_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = count == '0;
  assign level = count;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop && !empty);
    end
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[rtl/adsr_sns_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module adsr_sns_div
  import adsr_sns_pkg::*;
(
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [STG_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [REM_W-1:0] rem_q [QUO_W];
  logic [STG_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [STG_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [REM_W-1:0] dsh;
    logic             ge;
    logic [QUO_W-1:0] quo_nx;

    if (k == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      dsh    = REM_W'(den_in) << (QUO_W - 1 - k);
      ge     = rem_in >= dsh;
      quo_nx = quo_in;
      quo_nx[QUO_W-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      rem_q[k] <= ge ? rem_in - dsh : rem_in;
      den_q[k] <= den_in;
      quo_q[k] <= quo_nx;
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

[rtl/adsr_sns_back.sv]
// Back end: phase, sine lookup, envelope division and final scaling of each sample.
module adsr_sns_back
  import adsr_sns_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          q_empty,
  input  work_t                         q_data,
  output logic                          pop,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic [1:0]                    stage,
  output logic                          past_end
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam int SD_LEN = DIV_LAT - 2;

  logic                   b0_v;
  work_t                  b0;
  logic [PHASE_BITS-1:0]  p1;
  logic [SINE_INDEX_BITS-1:0] sidx;
  logic [ROM_AW-1:0]      rom_addr;
  logic [MAG_W-1:0]       p2_mag;
  logic                   p2_neg;
  logic [MAG_W-1:0]       sd_mag [SD_LEN];
  logic                   sd_neg [SD_LEN];
  logic                   sb_v    [DIV_LAT];
  logic                   sb_past [DIV_LAT];
  stage_t                 sb_stg  [DIV_LAT];
  logic [QUO_W-1:0]       quo;
  logic [AMP_W-1:0]       amp;
  logic [MAG_W+AMP_W:0]   scaled;
  logic [SAMPLE_BITS-1:0] mag_out;
  logic [PHASE_BITS+IDX_W-1:0] phase_full;

  assign pop = !q_empty;

  adsr_sns_div u_div (
    .clk (clk),
    .num (b0.num),
    .den (b0.den),
    .quo (quo)
  );

  assign phase_full = (PHASE_BITS + IDX_W)'(b0.step) * (PHASE_BITS + IDX_W)'(b0.idx);

  always_comb begin
    sidx = p1[PHASE_BITS-1 -: SINE_INDEX_BITS];
    // mirror the odd quadrants
    if (sidx[SINE_INDEX_BITS-2]) begin
      rom_addr = ROM_AW'(QUARTER) - {1'b0, sidx[SINE_INDEX_BITS-3:0]};
    end else begin
      rom_addr = {1'b0, sidx[SINE_INDEX_BITS-3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
      done <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) begin
        sb_v[k] <= 1'b0;
      end
    end else begin
      b0_v    <= pop;
      sb_v[0] <= b0_v;
      for (int k = 1; k < DIV_LAT; k++) begin
        sb_v[k] <= sb_v[k-1];
      end
      done <= sb_v[DIV_LAT-1];
    end
    b0         <= q_data;
    p1         <= phase_full[PHASE_BITS-1:0];
    p2_mag     <= SINE_ROM[rom_addr];
    p2_neg     <= sidx[SINE_INDEX_BITS-1];
    sd_mag[0]  <= p2_mag;
    sd_neg[0]  <= p2_neg;
    for (int k = 1; k < SD_LEN; k++) begin
      sd_mag[k] <= sd_mag[k-1];
      sd_neg[k] <= sd_neg[k-1];
    end
    sb_past[0] <= b0.past_end;
    sb_stg[0]  <= b0.stage;
    for (int k = 1; k < DIV_LAT; k++) begin
      sb_past[k] <= sb_past[k-1];
      sb_stg[k]  <= sb_stg[k-1];
    end
  end

  always_comb begin
    case (sb_stg[DIV_LAT-1])
      STG_ATTACK:  amp = quo;
      STG_DECAY:   amp = AMP_ONE - quo;
      STG_SUSTAIN: amp = AMP_W'(cfg.sus_level);
      STG_RELEASE: amp = quo;
      default:     amp = quo;
    endcase
    scaled  = (MAG_W + AMP_W + 1)'(sd_mag[SD_LEN-1] * amp) + (MAG_W + AMP_W + 1)'(32768);
    mag_out = SAMPLE_BITS'(scaled >> 16);
  end

  always_ff @(posedge clk) begin
    past_end <= sb_past[DIV_LAT-1];
    stage    <= sb_stg[DIV_LAT-1];
    if (sb_past[DIV_LAT-1]) begin
      sample <= '0;
    end else if (sd_neg[SD_LEN-1]) begin
      sample <= -$signed(mag_out);
    end else begin
      sample <= $signed(mag_out);
    end
  end

endmodule

[rtl/adsr_sine_note_sample_top.sv]
// Top level of the ADSR sine note sample block: register port, front, queue and back.
//
// Request channel: drive semitone, octave, note_length and sample_index with start
// high; the request is taken at a rising edge where start is high and busy is low.
// One request may be taken every cycle; busy rises only if the queue between the
// front and back ends could overflow, which an always-running back end prevents.
// Result channel: sample, stage and past_end are valid for exactly one cycle while
// done is high. done rises once the request has passed the two front registers, the
// queue, the back end input register, the 17-stage envelope divider and the output
// register; the result is taken at the rising edge where done is high. Results leave
// in request order, one per cycle at full rate.
// The receiver cannot stall, so results are never held back.
// Register port: APB style, registers at byte addresses 0, 4, 8, 12, 16 (phase step
// of A4, attack, decay, release lengths, sustain level); pready is always high.
// Write registers only while no request is in flight.
// Reset (rst, synchronous) empties the pipeline and queue and loads register
// defaults; no result is produced until a new request is taken.
module adsr_sine_note_sample_top
  import adsr_sns_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    semitone,
  input  logic [3:0]                    octave,
  input  logic [LEN_W-1:0]              note_length,
  input  logic [IDX_W-1:0]              sample_index,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic [1:0]                    stage,
  output logic                          past_end
);

  cfg_t              cfg;
  reg_idx_t          reg_sel;
  logic              wr_en;
  logic              push;
  work_t             push_data;
  logic              pop;
  work_t             q_data;
  logic              q_empty;
  logic [QCNT_W-1:0] q_level;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a4_phase_step   <= A4_W'(39370534);
      cfg.attack_samples  <= STG_W'(480);
      cfg.decay_samples   <= STG_W'(4800);
      cfg.release_samples <= STG_W'(4800);
      cfg.sus_level       <= SUS_W'(45875);
    end else if (wr_en) begin
      case (reg_sel)
        REG_A4:      cfg.a4_phase_step   <= pwdata;
        REG_ATTACK:  cfg.attack_samples  <= pwdata[STG_W-1:0];
        REG_DECAY:   cfg.decay_samples   <= pwdata[STG_W-1:0];
        REG_RELEASE: cfg.release_samples <= pwdata[STG_W-1:0];
        REG_SUSTAIN: cfg.sus_level       <= pwdata[SUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_A4:      prdata = cfg.a4_phase_step;
      REG_ATTACK:  prdata = 32'(cfg.attack_samples);
      REG_DECAY:   prdata = 32'(cfg.decay_samples);
      REG_RELEASE: prdata = 32'(cfg.release_samples);
      REG_SUSTAIN: prdata = 32'(cfg.sus_level);
      default:     prdata = '0;
    endcase
  end

  adsr_sns_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .semitone     (semitone),
    .octave       (octave),
    .note_length  (note_length),
    .sample_index (sample_index),
    .q_level      (q_level),
    .busy         (busy),
    .push         (push),
    .push_data    (push_data)
  );

  adsr_sns_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (q_data),
    .empty (q_empty),
    .level (q_level)
  );

  adsr_sns_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .pop      (pop),
    .done     (done),
    .sample   (sample),
    .stage    (stage),
    .past_end (past_end)
  );

endmodule

[tb/sv/adsr_sine_note_sample_top_test.sv]
// Testbench for the ADSR sine note sample block: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module adsr_sine_note_sample_top_test
  import adsr_sns_pkg::*;
();

  localparam int NUM_REGS     = 5;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_ITEMS   = 1600;

  typedef struct {
    logic [3:0]       semi;
    logic [3:0]       oct;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] idx;
  } note_req_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    stage_t                        stg;
    logic                          past;
  } note_sample_t;

  class note_sample_board;
    logic [31:0]      a4_step;
    logic [STG_W-1:0] att_len, dec_len, rel_len;
    logic [SUS_W-1:0] sus_lvl;
    note_sample_t     pending[$];
    int               errors;
    int               requests;
    int               stage_hits[4];
    int               past_hits;

    function void load_defaults();
      a4_step = 32'd39370534;
      att_len = 20'd480;
      dec_len = 20'd4800;
      rel_len = 20'd4800;
      sus_lvl = 16'd45875;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      case (idx)
        REG_A4:      a4_step = val;
        REG_ATTACK:  att_len = val[STG_W-1:0];
        REG_DECAY:   dec_len = val[STG_W-1:0];
        REG_RELEASE: rel_len = val[STG_W-1:0];
        REG_SUSTAIN: sus_lvl = val[SUS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned semitone_ratio(int s);
      longint unsigned tbl[12] = '{38968, 41285, 43740, 46341, 49097, 52016,
                                   55109, 58386, 61858, 65536, 69433, 73562};
      return tbl[s];
    endfunction

    // signed sine at full scale from the top 12 phase bits
    function longint phase_to_sine(logic [31:0] phase);
      longint unsigned full, q, t, t2, term, mag;
      longint          sum;
      logic [11:0]     top;
      logic [1:0]      quad;
      full = 64'd32767;
      top  = phase[31:20];
      quad = top[11:10];
      q    = quad[0] ? (64'd1024 - top[9:0]) : top[9:0];
      t    = (q * 64'd1686629713) >> 10;
      t2   = (t * t) >> 30;
      term = t;
      sum  = longint'(t);
      for (int k = 1; k <= 5; k++) begin
        term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      mag = (longint'(sum) * full + (64'd1 << 29)) >> 30;
      if (mag > full) mag = full;
      return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    function void note_request(note_req_t r);
      note_sample_t    e;
      longint unsigned i, len, ratio, sh, step, amp, mag;
      logic [31:0]     phase;
      longint          sine;
      int              s;
      i   = r.idx;
      len = r.len;
      requests++;
      if (i >= len + rel_len) begin
        e.smp  = '0;
        e.stg  = STG_RELEASE;
        e.past = 1'b1;
        past_hits++;
        pending.push_back(e);
        return;
      end
      s = r.semi;
      if (s >= 12) begin
        ratio = semitone_ratio(s - 12);
        sh    = 19 - r.oct;
      end else begin
        ratio = semitone_ratio(s);
        sh    = 20 - r.oct;
      end
      step  = ((longint'(a4_step) * ratio + (64'd1 << (sh - 1))) >> sh) & 64'hFFFF_FFFF;
      phase = 32'(step * i);
      if (i < att_len) begin
        e.stg = STG_ATTACK;
        amp   = (i << 16) / att_len;
      end else if (i < longint'(att_len) + dec_len) begin
        e.stg = STG_DECAY;
        amp   = 65536 - ((i - att_len) * (65536 - sus_lvl)) / dec_len;
      end else if (i < len) begin
        e.stg = STG_SUSTAIN;
        amp   = sus_lvl;
      end else begin
        e.stg = STG_RELEASE;
        amp   = (longint'(sus_lvl) * (len + rel_len - i)) / rel_len;
      end
      sine   = phase_to_sine(phase);
      mag    = ((sine < 0 ? -sine : sine) * amp + 32768) >> 16;
      e.smp  = SAMPLE_BITS'(sine < 0 ? -longint'(mag) : longint'(mag));
      e.past = 1'b0;
      stage_hits[e.stg]++;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [SAMPLE_BITS-1:0] smp, logic [1:0] stg,
                               logic past);
      note_sample_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: sample %0d stage %0d past_end %0b",
                 $time, smp, stg, past);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (smp !== e.smp) begin
        $display("%0t: sample expected %0d actual %0d", $time, e.smp, smp);
        errors++;
      end
      if (stg !== e.stg) begin
        $display("%0t: stage expected %0d actual %0d", $time, e.stg, stg);
        errors++;
      end
      if (past !== e.past) begin
        $display("%0t: past_end expected %0b actual %0b", $time, e.past, past);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel, penable, pwrite;
  logic [4:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          start;
  logic                          busy;
  logic [3:0]                    semitone, octave;
  logic [LEN_W-1:0]              note_length;
  logic [IDX_W-1:0]              sample_index;
  logic                          done;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [1:0]                    stage;
  logic                          past_end;

  note_sample_board board;
  int               idle_cycles;
  int               phases;

  adsr_sine_note_sample_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .semitone(semitone), .octave(octave),
    .note_length(note_length), .sample_index(sample_index), .done(done),
    .sample(sample), .stage(stage), .past_end(past_end)
  );

  always #4 clk = ~clk;

  // monitor: note taken requests, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_request('{semitone, octave, note_length, sample_index});
      end
      if (done) begin
        board.check_result(sample, stage, past_end);
      end
      if ((start && !busy) || done) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("adsr_sine_note_sample_top: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(int idx, logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 5'(4 * idx);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic write_all(logic [31:0] a4, logic [19:0] att, logic [19:0] dec,
                           logic [19:0] rel, logic [15:0] sus);
    write_reg(REG_A4, a4);
    write_reg(REG_ATTACK, 32'(att));
    write_reg(REG_DECAY, 32'(dec));
    write_reg(REG_RELEASE, 32'(rel));
    write_reg(REG_SUSTAIN, 32'(sus));
    phases++;
  endtask

  // hold inputs until the request is taken, then, if may_gap is set, sometimes idle for a random gap
  task automatic send_note(logic [3:0] semi, logic [3:0] oct, logic [LEN_W-1:0] len,
                           logic [IDX_W-1:0] idx, bit may_gap);
    int gap;
    start        = 1'b1;
    semitone     = semi;
    octave       = oct;
    note_length  = len;
    sample_index = idx;
    do @(posedge clk); while (busy);
    @(negedge clk);
    gap = 0;
    if (may_gap) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index(logic [LEN_W-1:0] len);
    longint unsigned a, ad, l, lr, v;
    a  = board.att_len;
    ad = a + board.dec_len;
    l  = len;
    lr = l + board.rel_len;
    case ($urandom_range(0, 7))
      0:       v = $urandom;
      1:       v = (a > 0) ? $urandom_range(0, 32'(a - 1)) : 0;
      2:       v = a + $urandom_range(0, 32'(board.dec_len));
      3:       v = ad + $urandom_range(0, 32'(l > ad ? l - ad : 1));
      4:       v = l + $urandom_range(0, 32'(board.rel_len));
      5:       v = lr + $urandom_range(0, 4) - 2;
      6:       v = a + $urandom_range(0, 4) - 2;
      default: v = ad + $urandom_range(0, 4) - 2;
    endcase
    return IDX_W'(v);
  endfunction

  task automatic random_notes(int count);
    logic [LEN_W-1:0] len;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) len = LEN_W'($urandom);
      else len = LEN_W'($urandom_range(0, 30000));
      send_note(4'($urandom), ($urandom_range(0, 5) == 0) ? 4'($urandom) :
                4'($urandom_range(0, 8)), len, pick_index(len), 1'b1);
    end
  endtask

  initial begin
    board = new();
    board.load_defaults();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; semitone = '0; octave = '0; note_length = '0; sample_index = '0;
    idle_cycles = 0;
    phases = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // reset settings: note sweep, field extremes, stage borders
    for (int s = 0; s < 16; s++) begin
      send_note(4'(s), (s % 2) ? 4'd4 : 4'd15, 24'd20000, 25'(3000 + 97 * s), 1'b0);
    end
    send_note(4'd9, 4'd0, 24'd0, 25'd0, 1'b0);
    send_note(4'd11, 4'd8, 24'hFFFFFF, 25'h1FFFFFF, 1'b0);
    send_note(4'd0, 4'd0, 24'hFFFFFF, 25'd5279, 1'b0);
    send_note(4'd3, 4'd4, 24'd100, 25'd200, 1'b0);
    send_note(4'd5, 4'd4, 24'd10000, 25'd14799, 1'b0);
    send_note(4'd5, 4'd4, 24'd10000, 25'd14800, 1'b0);
    send_note(4'd15, 4'd15, 24'd6000, 25'd479, 1'b0);
    drain();
    // bus writes past the last register are dropped
    write_reg(NUM_REGS, 32'hFFFF_FFFF);
    random_notes(RAND_ITEMS / 8);
    drain();

    // zero-length stages, largest step, silent sustain
    write_all(32'hFFFF_FFFF, 20'd0, 20'd0, 20'd0, 16'd0);
    random_notes(RAND_ITEMS / 8);
    drain();
    // longest stages, zero step, full sustain
    write_all(32'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    random_notes(RAND_ITEMS / 16);
    drain();
    write_all(32'd39370534, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    random_notes(RAND_ITEMS / 16);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_all($urandom, 20'($urandom_range(0, 3000)), 20'($urandom_range(0, 8000)),
                20'($urandom_range(0, 8000)), 16'($urandom));
      random_notes(RAND_ITEMS / 8);
      drain();
    end
    write_all($urandom, 20'($urandom), 20'($urandom), 20'($urandom), 16'($urandom));
    random_notes(RAND_ITEMS / 16);
    drain();

    $display("Covered %0d requests over %0d register settings plus reset values.",
             board.requests, phases);
    $display("Stages attack/decay/sustain/release: %0d/%0d/%0d/%0d, past end: %0d.",
             board.stage_hits[0], board.stage_hits[1], board.stage_hits[2],
             board.stage_hits[3], board.past_hits);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("adsr_sine_note_sample_top: match");
    end else begin
      $display("adsr_sine_note_sample_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/adsr_sns_pkg.sv
rtl/adsr_sns_front.sv
rtl/adsr_sns_queue.sv
rtl/adsr_sns_div.sv
rtl/adsr_sns_back.sv
rtl/adsr_sine_note_sample_top.sv
tb/sv/adsr_sine_note_sample_top_test.sv
